// ----- hw/rtl/fmcd_pkg.sv -----
`default_nettype none

package fmcd_pkg;

  // Field widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 10;   // R+G+B
  localparam int unsigned SumW    = 34;
  localparam int unsigned CountW  = 24;
  localparam int unsigned MeanW   = 18;   // unsigned Q10.8
  localparam int unsigned FracW   = 8;

  // Pixel bound per frame; the counter also stops at its own full scale
  localparam longint unsigned MaxPixels = 64'd16777215;
  localparam longint unsigned CountMax  = (64'd1 << CountW) - 64'd1;
  localparam logic [CountW-1:0] CountLimit =
    CountW'((MaxPixels < CountMax) ? MaxPixels : CountMax);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // Restoring divider: one quotient bit per cycle
  localparam int unsigned DivSteps = MeanW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(DivSteps - 1);

  // Largest possible mean, 765 in Q10.8
  localparam logic [MeanW-1:0] MeanMax = MeanW'(765 << FracW);

  // Sequencer states
  localparam int unsigned StateW = 2;
  localparam logic [StateW-1:0] StIdle = 2'd0;
  localparam logic [StateW-1:0] StDiv  = 2'd1;
  localparam logic [StateW-1:0] StFin  = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/frame_mean_change_detector.sv -----
`default_nettype none

// Frame mean change detector. Pixels stream in one per cycle; each beat adds
// R+G+B into a 34-bit sum and counts the pixel (both saturate at the pixel
// bound, which sets the overflow flag). After the beat that carries
// end_of_frame, a single restoring divider forms sum*256/count one quotient
// bit per step, and the final state compares the Q10.8 mean with the
// previous frame's mean +/- change_threshold and loads the result register
// once the previous result has been taken. So in_ready_o stays low after
// each end-of-frame beat until the result is loaded; within a frame the block
// takes one pixel per cycle. The mean of each frame becomes the reference for
// the next. change_threshold may be written only while the block is idle.

module frame_mean_change_detector (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [fmcd_pkg::MeanW-1:0]   cfg_wdata_i,
  // pixel channel
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [fmcd_pkg::ChanW-1:0]   red_i,
  input  wire logic [fmcd_pkg::ChanW-1:0]   green_i,
  input  wire logic [fmcd_pkg::ChanW-1:0]   blue_i,
  input  wire logic                         end_of_frame_i,
  // result channel
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         keep_frame_o,
  output      logic [fmcd_pkg::MeanW-1:0]   frame_mean_o,
  output      logic                         overflow_o
);
  import fmcd_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;

  logic [MeanW-1:0]  thr_q;
  logic [MeanW-1:0]  prev_q, prev_d;

  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic              sat_q, sat_d;

  // divider registers
  logic [CountW-1:0] rem_q, rem_d;
  logic [MeanW-1:0]  quo_q, quo_d;    // dividend bits shift out, quotient in
  logic [CountW-1:0] div_q, div_d;
  logic              ovf_q, ovf_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              keep_q, keep_d;
  logic [MeanW-1:0]  mean_q, mean_d;
  logic              ovf_out_q, ovf_out_d;

  logic              in_fire;
  logic [PixW-1:0]   pix;
  logic [SumW:0]     sum_add;
  logic [SumW-1:0]   sum_acc;
  logic [CountW:0]   rem_shift;
  logic [CountW+1:0] rem_diff;
  logic              rem_ge;
  logic [MeanW:0]    mean_plus_thr;
  logic [MeanW:0]    prev_plus_thr;
  logic              lo_ok, hi_ok;
  logic              fin_go;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // pixel sum, saturating at full scale
  assign pix     = PixW'(red_i) + PixW'(green_i) + PixW'(blue_i);
  assign sum_add = {1'b0, sum_q} + (SumW + 1)'(pix);
  assign sum_acc = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];

  // one restoring step
  assign rem_shift = {rem_q, quo_q[MeanW-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_q};
  assign rem_ge    = !rem_diff[CountW+1];

  // band test: inside when prev - thr < mean < prev + thr
  assign mean_plus_thr = {1'b0, quo_q} + {1'b0, thr_q};
  assign prev_plus_thr = {1'b0, prev_q} + {1'b0, thr_q};
  assign lo_ok = {1'b0, prev_q} < mean_plus_thr;
  assign hi_ok = prev_plus_thr > {1'b0, quo_q};

  assign fin_go = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    count_d     = count_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    keep_d      = keep_q;
    mean_d      = mean_q;
    ovf_out_d   = ovf_out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (count_q < CountLimit) begin
            count_d = count_q + CountW'(1);
            sum_d   = sum_acc;
          end else begin
            sat_d = 1'b1;
          end
          if (end_of_frame_i) begin
            // load divider: high dividend bits seed the remainder
            rem_d   = sum_d[SumW-1:SumW-CountW];
            quo_d   = {sum_d[SumW-CountW-1:0], FracW'(0)};
            div_d   = count_d;
            ovf_d   = sat_d;
            step_d  = '0;
            sum_d   = '0;
            count_d = '0;
            sat_d   = 1'b0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d = rem_ge ? rem_diff[CountW-1:0] : rem_shift[CountW-1:0];
        quo_d = {quo_q[MeanW-2:0], rem_ge};
        if (step_q == LastStep) begin
          state_d = StFin;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StFin: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          keep_d      = !(lo_ok && hi_ok);
          mean_d      = quo_q;
          ovf_out_d   = ovf_q;
          prev_d      = quo_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      thr_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_q     <= div_d;
    ovf_q     <= ovf_d;
    keep_q    <= keep_d;
    mean_q    <= mean_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign keep_frame_o = keep_q;
  assign frame_mean_o = mean_q;
  assign overflow_o   = ovf_out_q;

`ifndef SYNTHESIS
  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  // a new result only comes out of the final state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFin))
    else $error("result appeared outside the final state");

  // mean never exceeds three full-scale channels
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (mean_q <= MeanMax))
    else $error("frame mean out of range");

  // the divider always spends its full step count
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && $past(state_q) == StDiv) |-> ($past(step_q) == LastStep))
    else $error("divider left early");
`endif

endmodule

`default_nettype wire
